### rtl/core/ils_pkg.sv
package ils_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int OP_W = 3;
	localparam int POS_W = 7;
	localparam int DATA_W = 32;
	localparam int LEN_W = 7;

	typedef enum logic [OP_W-1:0] {
		OP_GET      = 3'd0,
		OP_ADD_HEAD = 3'd1,
		OP_ADD_TAIL = 3'd2,
		OP_ADD_AT   = 3'd3,
		OP_DEL      = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_RANGE    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic              ins;
		logic              del;
		logic [DATA_W-1:0] value;
	} cell_ctl_t;

endpackage

### rtl/core/ils_if.sv
interface ils_req_if;
	logic                           valid;
	logic                           ready;
	logic [ils_pkg::OP_W-1:0]       op;
	logic [ils_pkg::POS_W-1:0]      position;
	logic signed [ils_pkg::DATA_W-1:0] value;

	modport source (output valid, op, position, value, input ready);
	modport sink (input valid, op, position, value, output ready);
endinterface

interface ils_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [ils_pkg::DATA_W-1:0] read_value;
	logic [1:0]                        status;
	logic [ils_pkg::LEN_W-1:0]         length;

	modport source (output valid, read_value, status, length, input ready);
	modport sink (input valid, read_value, status, length, output ready);
endinterface

### rtl/core/ils_cell.sv
module ils_cell #(
	parameter int IDX = 0,
	parameter int PW = 7
) (
	input  logic                          clk,
	input  ils_pkg::cell_ctl_t            ctl,
	input  logic [PW-1:0]                 pos,
	input  logic [ils_pkg::DATA_W-1:0]    left,
	input  logic [ils_pkg::DATA_W-1:0]    right,
	output logic [ils_pkg::DATA_W-1:0]    q,
	output logic [ils_pkg::DATA_W-1:0]    hit
);

	logic [PW-1:0]              idx;
	logic [ils_pkg::DATA_W-1:0] data_q;
	logic                       at_pos;
	logic                       past_pos;

	assign idx      = PW'(IDX);
	assign at_pos   = (idx == pos);
	assign past_pos = (idx > pos);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (at_pos) begin
				data_q <= ctl.value;
			end else if (past_pos) begin
				data_q <= left;
			end
		end else if (ctl.del && (at_pos || past_pos)) begin
			data_q <= right;
		end
	end

	assign q   = data_q;
	assign hit = at_pos ? data_q : '0;

endmodule

### rtl/core/indexed_list_store_top.sv
// Ordered list of signed 32-bit values, head at index 0, held in a row of CAPACITY
// register cells. Insert shifts the tail one cell toward the end, delete shifts it one
// cell back, and get selects one cell; a new request is taken in each cycle while the
// result register is empty or being drained, so the sustained rate is one transaction
// per clock. Each request gives exactly one response with the read value (-1 on a get
// past the end, 0 for non-get operations), a status (done, out of range, full, not found)
// and the length after the request.
module indexed_list_store_top #(
	parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	ils_req_if.sink   req,
	ils_rsp_if.source rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W;
	localparam int DW = ils_pkg::DATA_W;

	logic [CW-1:0]        cnt_q;
	logic [PW-1:0]        pos_e;
	logic [PW-1:0]        cnt_e;
	logic [PW-1:0]        cnt_nxt;
	logic [PW-1:0]        eff_pos;
	logic                 accept;
	logic                 full;
	logic                 do_ins;
	logic                 do_del;
	logic [DW-1:0]        rd;
	logic [DW-1:0]        rd_sel;
	ils_pkg::status_t     st;
	ils_pkg::cell_ctl_t   ctl;

	logic [DW-1:0]        cell_q   [CAPACITY];
	logic [DW-1:0]        cell_hit [CAPACITY];

	logic                 valid_q;
	logic [DW-1:0]        rd_q;
	ils_pkg::status_t     status_q;
	logic [ils_pkg::LEN_W-1:0] length_q;

	assign req.ready = !valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign pos_e     = PW'(req.position);
	assign cnt_e     = PW'(cnt_q);
	assign full      = (cnt_e == PW'(CAPACITY));

	always_comb begin
		rd_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_sel = rd_sel | cell_hit[i];
		end
	end

	always_comb begin
		do_ins  = 1'b0;
		do_del  = 1'b0;
		eff_pos = pos_e;
		rd      = '0;
		st      = ils_pkg::ST_RANGE;
		case (req.op)
			ils_pkg::OP_GET: begin
				if (pos_e < cnt_e) begin
					rd = rd_sel;
					st = ils_pkg::ST_DONE;
				end else begin
					rd = '1;
					st = ils_pkg::ST_NOTFOUND;
				end
			end
			ils_pkg::OP_ADD_HEAD, ils_pkg::OP_ADD_TAIL, ils_pkg::OP_ADD_AT: begin
				if (req.op == ils_pkg::OP_ADD_HEAD) begin
					eff_pos = '0;
				end else if (req.op == ils_pkg::OP_ADD_TAIL) begin
					eff_pos = cnt_e;
				end
				if ((req.op == ils_pkg::OP_ADD_AT) && (pos_e > cnt_e)) begin
					st = ils_pkg::ST_RANGE;
				end else if (full) begin
					st = ils_pkg::ST_FULL;
				end else begin
					st     = ils_pkg::ST_DONE;
					do_ins = 1'b1;
				end
			end
			ils_pkg::OP_DEL: begin
				if (pos_e < cnt_e) begin
					st     = ils_pkg::ST_DONE;
					do_del = 1'b1;
				end
			end
			default: begin
				st = ils_pkg::ST_RANGE;
			end
		endcase
	end

	always_comb begin
		cnt_nxt = cnt_e;
		if (do_ins) begin
			cnt_nxt = cnt_e + PW'(1);
		end else if (do_del) begin
			cnt_nxt = cnt_e - PW'(1);
		end
	end

	assign ctl.ins   = accept && do_ins;
	assign ctl.del   = accept && do_del;
	assign ctl.value = req.value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DW-1:0] left_d;
		logic [DW-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = req.value;
		end else begin : g_mid
			assign left_d = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_inner
			assign right_d = cell_q[i+1];
		end
		ils_cell #(
			.IDX(i),
			.PW (PW)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.pos  (eff_pos),
			.left (left_d),
			.right(right_d),
			.q    (cell_q[i]),
			.hit  (cell_hit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q   <= cnt_nxt[CW-1:0];
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q     <= rd;
			status_q <= st;
			length_q <= cnt_nxt[ils_pkg::LEN_W-1:0];
		end
	end

	assign rsp.valid      = valid_q;
	assign rsp.read_value = rd_q;
	assign rsp.status     = status_q;
	assign rsp.length     = length_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		PW'(cnt_q) <= PW'(CAPACITY))
		else $error("element count above capacity");

	a_accept_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp.valid)
		else $error("accepted request gave no response");

	a_del_dec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.del |=> (cnt_q == $past(cnt_q) - CW'(1)))
		else $error("delete did not shrink the list");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && st == ils_pkg::ST_FULL) |=> (cnt_q == $past(cnt_q)))
		else $error("insert into full store changed the count");

	a_len_match: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (rsp.length == ils_pkg::LEN_W'(cnt_q)))
		else $error("reported length differs from count");

endmodule

### tb/indexed_list_store_top_test.sv
module indexed_list_store_top_test;
	import ils_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_UNUSED_LAST = 3'd7;
	localparam int LONG_HOLD = 200;
	localparam int SETTLE_CYCLES = 10;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] val;
		int unsigned       gap;
		bit                drain;
	} list_req_t;

	typedef struct {
		logic [DATA_W-1:0] rd;
		status_t           st;
		logic [LEN_W-1:0]  len;
	} list_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              drv_valid = 1'b0;
	logic [OP_W-1:0]   drv_op = '0;
	logic [POS_W-1:0]  drv_pos = '0;
	logic [DATA_W-1:0] drv_val = '0;
	logic              rsp_ready = 1'b0;

	ils_req_if req_if ();
	ils_rsp_if rsp_if ();

	assign req_if.valid = drv_valid;
	assign req_if.op = drv_op;
	assign req_if.position = drv_pos;
	assign req_if.value = drv_val;
	assign rsp_if.ready = rsp_ready;

	indexed_list_store_top #(
		.CAPACITY(CAP)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	always #10 clk = ~clk;

	list_req_t pending_reqs[$];
	list_rsp_t expected_rsps[$];

	// shadow of the list contents
	logic [DATA_W-1:0] list_mem[CAP];
	int list_len = 0;

	// stimulus-side length estimate, used only to aim positions
	int gen_len = 0;

	int sent_cnt = 0;
	int recv_cnt = 0;
	int err_cnt = 0;

	function automatic list_rsp_t predict_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
		logic [DATA_W-1:0] val);
		list_rsp_t r;
		int at;
		r.rd = '0;
		r.st = ST_RANGE;
		at = -1;
		case (op)
			OP_GET: begin
				if (pos < list_len) begin
					r.rd = list_mem[pos];
					r.st = ST_DONE;
				end else begin
					r.rd = '1;
					r.st = ST_NOTFOUND;
				end
			end
			OP_ADD_HEAD: at = 0;
			OP_ADD_TAIL: at = list_len;
			OP_ADD_AT: begin
				if (pos <= list_len)
					at = pos;
			end
			OP_DEL: begin
				if (pos < list_len) begin
					for (int i = pos; i < list_len - 1; i++)
						list_mem[i] = list_mem[i + 1];
					list_len--;
					r.st = ST_DONE;
				end
			end
			default: ;
		endcase
		if (at >= 0) begin
			if (list_len >= CAP) begin
				r.st = ST_FULL;
			end else begin
				for (int i = list_len; i > at; i--)
					list_mem[i] = list_mem[i - 1];
				list_mem[at] = val;
				list_len++;
				r.st = ST_DONE;
			end
		end
		r.len = list_len[LEN_W-1:0];
		return r;
	endfunction

	function automatic void queue_req(logic [OP_W-1:0] op, int pos, logic [DATA_W-1:0] val,
		bit burst, bit drain);
		list_req_t it;
		it.op = op;
		it.pos = pos[POS_W-1:0];
		it.val = val;
		it.gap = burst ? 0 : $urandom_range(0, 4);
		it.drain = drain;
		pending_reqs.push_back(it);
		case (op)
			OP_ADD_HEAD, OP_ADD_TAIL: if (gen_len < CAP) gen_len++;
			OP_ADD_AT: if (gen_len < CAP && pos <= gen_len) gen_len++;
			OP_DEL: if (pos < gen_len) gen_len--;
			default: ;
		endcase
	endfunction

	function automatic int pick_pos();
		int p;
		case ($urandom_range(0, 9))
			0: p = gen_len;
			1: p = gen_len + 1;
			2: p = $urandom_range(0, CAP);
			default: p = (gen_len == 0) ? 0 : $urandom_range(0, gen_len - 1);
		endcase
		return (p > CAP) ? CAP : p;
	endfunction

	function automatic logic [DATA_W-1:0] pick_val();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '1;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : req_drive
		list_req_t nxt;
		int sent_now;
		int unsigned gap_cnt;
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_op <= '0;
			drv_pos <= '0;
			drv_val <= '0;
			sent_cnt <= 0;
			gap_cnt = 0;
		end else begin
			sent_now = sent_cnt;
			if (drv_valid && req_if.ready) begin
				expected_rsps.push_back(predict_list_op(drv_op, drv_pos, drv_val));
				sent_now++;
			end
			sent_cnt <= sent_now;
			if (!drv_valid || req_if.ready) begin
				if (pending_reqs.size() == 0) begin
					drv_valid <= 1'b0;
				end else if (pending_reqs[0].drain && sent_now != recv_cnt) begin
					drv_valid <= 1'b0;
				end else if (gap_cnt < pending_reqs[0].gap) begin
					drv_valid <= 1'b0;
					gap_cnt++;
				end else begin
					nxt = pending_reqs.pop_front();
					drv_valid <= 1'b1;
					drv_op <= nxt.op;
					drv_pos <= nxt.pos;
					drv_val <= nxt.val;
					gap_cnt = 0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : rsp_check
		list_rsp_t want;
		int hold_left;
		int long_left;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			recv_cnt <= 0;
			hold_left = 0;
			long_left = 0;
		end else begin
			if (rsp_if.valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$error("response with no request outstanding");
					err_cnt++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_if.read_value !== want.rd) begin
						$error("read_value: expected %0d, got %0d", $signed(want.rd),
							$signed(rsp_if.read_value));
						err_cnt++;
					end
					if (rsp_if.status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, rsp_if.status);
						err_cnt++;
					end
					if (rsp_if.length !== want.len) begin
						$error("length: expected %0d, got %0d", want.len, rsp_if.length);
						err_cnt++;
					end
				end
				recv_cnt <= recv_cnt + 1;
				if (recv_cnt + 1 == 120 || recv_cnt + 1 == 450)
					long_left = LONG_HOLD;
				hold_left = ((recv_cnt / 64) % 3 == 1) ? 0 : $urandom_range(0, 4);
			end
			if (long_left > 0) begin
				long_left--;
				rsp_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin : stim
		int r;
		int mode;
		bit burst;
		logic [OP_W-1:0] op;

		// empty list corner cases, then head and tail inserts
		queue_req(OP_DEL, 0, '0, 1'b0, 1'b0);
		queue_req(OP_GET, 0, '0, 1'b0, 1'b0);
		queue_req(OP_GET, CAP, '0, 1'b0, 1'b0);
		queue_req(OP_ADD_AT, 1, 32'h1234_5678, 1'b0, 1'b0);
		queue_req(OP_ADD_AT, 0, '0, 1'b0, 1'b0);
		queue_req(OP_ADD_HEAD, 0, 32'h8000_0000, 1'b0, 1'b0);
		queue_req(OP_ADD_TAIL, 0, 32'h7fff_ffff, 1'b0, 1'b0);
		// index equal to length appends
		queue_req(OP_ADD_AT, 3, '1, 1'b0, 1'b0);
		queue_req(OP_ADD_AT, 5, 32'h5555_aaaa, 1'b0, 1'b0);
		queue_req(OP_ADD_AT, 2, 32'haaaa_5555, 1'b0, 1'b0);
		for (int i = 0; i <= 5; i++)
			queue_req(OP_GET, i, '0, 1'b1, 1'b0);
		queue_req(OP_DEL, 5, '0, 1'b0, 1'b0);
		queue_req(OP_DEL, 4, '0, 1'b0, 1'b0);
		queue_req(OP_DEL, 0, '0, 1'b0, 1'b0);
		queue_req(OP_DEL, 1, '0, 1'b0, 1'b0);
		for (logic [OP_W:0] u = {1'b0, OP_UNUSED_FIRST}; u <= {1'b0, OP_UNUSED_LAST}; u++)
			queue_req(u[OP_W-1:0], CAP, '1, 1'b0, 1'b0);
		queue_req(OP_GET, 1, '0, 1'b0, 1'b0);

		// random blocks: grow to full, dwell, mix, shrink toward empty
		for (int blk = 0; blk < 14; blk++) begin
			mode = blk % 4;
			burst = (blk % 5 == 2);
			for (int k = 0; k < 50; k++) begin
				r = $urandom_range(0, 99);
				case (mode)
					0, 1: op = (r < 10) ? OP_GET : (r < 85) ? OP_ADD_TAIL :
						(r < 95) ? OP_DEL : OP_UNUSED_FIRST;
					2: op = (r < 30) ? OP_GET : (r < 60) ? OP_ADD_TAIL :
						(r < 90) ? OP_DEL : OP_UNUSED_FIRST;
					default: op = (r < 10) ? OP_GET : (r < 20) ? OP_ADD_TAIL :
						(r < 95) ? OP_DEL : OP_UNUSED_FIRST;
				endcase
				if (op == OP_ADD_TAIL) begin
					case ($urandom_range(0, 2))
						0: op = OP_ADD_HEAD;
						1: op = OP_ADD_AT;
						default: ;
					endcase
				end else if (op == OP_UNUSED_FIRST) begin
					op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
				end
				queue_req(op, pick_pos(), pick_val(), burst, k == 0 && blk % 5 == 4);
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || drv_valid || expected_rsps.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_rsps.size() != 0) begin
			$error("%0d responses never arrived", expected_rsps.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : watchdog
		#5000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

### files.f
rtl/core/ils_pkg.sv
rtl/core/ils_if.sv
rtl/core/ils_cell.sv
rtl/core/indexed_list_store_top.sv
tb/indexed_list_store_top_test.sv
